@@ sv/lru_pr_pkg.sv @@
// Package for the LRU page replacement block.
// Holds the frame count, derived widths and the lookup result type.
// No dependencies; used by lru_pr_frames and lru_page_replacement.
package lru_pr_pkg;

    // Number of physical frames built into the store.
    localparam int FRAMES = 8;

    // Width of a page number and of the saturating counters.
    localparam int PAGE_W = 32;
    localparam int CNT_W  = 32;

    // Width of a recency rank and of the fill count.
    localparam int AGE_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W = $clog2(FRAMES + 1);

    // Width of the frame limit register and its reset value.
    localparam int LIM_W = 4;
    localparam logic [LIM_W-1:0] LIM_RESET = 4'd8;

    // Output item: hit, evicted, victim, hit total, fault total.
    localparam int OUT_BITS = 2 + PAGE_W + 2 * CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Lookup outcome for the item in flight.
    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [PAGE_W-1:0] victim;
    } lookup_t;

endpackage

@@ sv/lru_pr_frames.sv @@
// Frame store of the LRU page replacement block: page tags, valid bits,
// recency ranks and fill count, with parallel lookup and registered update.
// Depends on lru_pr_pkg.
module lru_pr_frames
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             upd,
    input  logic [lru_pr_pkg::PAGE_W-1:0]    page,
    input  logic [lru_pr_pkg::FILL_W-1:0]    lim,
    output lru_pr_pkg::lookup_t              lookup
);

    logic [lru_pr_pkg::PAGE_W-1:0] page_reg [lru_pr_pkg::FRAMES];
    logic [lru_pr_pkg::AGE_W-1:0]  age_reg  [lru_pr_pkg::FRAMES];
    logic [lru_pr_pkg::FRAMES-1:0] valid_reg;
    logic [lru_pr_pkg::FILL_W-1:0] filled_reg;

    logic [lru_pr_pkg::FRAMES-1:0] match_first;
    logic [lru_pr_pkg::FRAMES-1:0] old_first;
    logic [lru_pr_pkg::FRAMES-1:0] sel;
    logic                          hit;
    logic                          fill;
    logic [lru_pr_pkg::AGE_W-1:0]  hit_age;
    logic [lru_pr_pkg::FILL_W-1:0] oldest;
    logic [lru_pr_pkg::FILL_W-1:0] rank;
    logic [lru_pr_pkg::PAGE_W-1:0] victim;
    logic                          found_m;
    logic                          found_o;

    // Compare the page against every valid frame and find the least recent one.
    always_comb
    begin
        match_first = '0;
        old_first   = '0;
        found_m     = 1'b0;
        found_o     = 1'b0;
        hit_age     = '0;
        victim      = '0;
        oldest      = filled_reg - lru_pr_pkg::FILL_W'(1);
        for (int i = 0; i < lru_pr_pkg::FRAMES; i++)
        begin
            if (valid_reg[i] && (page_reg[i] == page) && !found_m)
            begin
                match_first[i] = 1'b1;
                found_m        = 1'b1;
                hit_age        = age_reg[i];
            end
            if (valid_reg[i] && (lru_pr_pkg::FILL_W'(age_reg[i]) == oldest) && !found_o)
            begin
                old_first[i] = 1'b1;
                found_o      = 1'b1;
                victim       = page_reg[i];
            end
        end
        hit  = found_m;
        fill = !hit && (filled_reg < lim);
    end

    // Pick the frame that becomes most recent and the rank it leaves.
    always_comb
    begin
        for (int i = 0; i < lru_pr_pkg::FRAMES; i++)
        begin
            if (hit)
            begin
                sel[i] = match_first[i];
            end
            else if (fill)
            begin
                sel[i] = (lru_pr_pkg::FILL_W'(i) == filled_reg);
            end
            else
            begin
                sel[i] = old_first[i];
            end
        end
        if (hit)
        begin
            rank = lru_pr_pkg::FILL_W'(hit_age);
        end
        else if (fill)
        begin
            rank = filled_reg;
        end
        else
        begin
            rank = oldest;
        end
    end

    assign lookup.hit     = hit;
    assign lookup.evicted = !hit && !fill;
    assign lookup.victim  = (!hit && !fill) ? victim : '0;

    // Control state: valid bits, ranks and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            filled_reg <= '0;
            for (int i = 0; i < lru_pr_pkg::FRAMES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            for (int i = 0; i < lru_pr_pkg::FRAMES; i++)
            begin
                if (sel[i])
                begin
                    age_reg[i] <= '0;
                end
                else if (valid_reg[i] && (lru_pr_pkg::FILL_W'(age_reg[i]) < rank))
                begin
                    age_reg[i] <= age_reg[i] + lru_pr_pkg::AGE_W'(1);
                end
            end
            if (fill)
            begin
                valid_reg  <= valid_reg | sel;
                filled_reg <= filled_reg + lru_pr_pkg::FILL_W'(1);
            end
        end
    end

    // Page tags are written on a fault only.
    always_ff @(posedge clk)
    begin
        if (upd && !hit)
        begin
            for (int i = 0; i < lru_pr_pkg::FRAMES; i++)
            begin
                if (sel[i])
                begin
                    page_reg[i] <= page;
                end
            end
        end
    end

    // Valid frames are always the low ones, one per filled slot.
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(filled_reg))
        else $error("valid bits disagree with fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        upd && (filled_reg >= lim) |=> filled_reg == $past(filled_reg))
        else $error("fill count grew past the frame limit");

endmodule

@@ sv/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: stream ports, input and
// result registers, frame limit register and saturating counters.
// Depends on lru_pr_pkg and lru_pr_frames.

// A fully associative store of eight page frames with least-recently-used
// replacement. Each item on the slave stream is one page access; each one
// gives exactly one result item on the master stream. The block takes one
// item per clock cycle when the output is not stalled. Each item is first
// captured in the input register; then, once the result slot is free, one
// pass through the parallel tag compare and rank update loads the result
// register. All frames are compared at once, so no memory port or
// iteration limits the rate. Frames are empty after reset with no clearing
// pass. The user must write the frame limit (cfg_wr_data) only while no
// item is in flight; the block itself does not enforce this.
module lru_page_replacement
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Frame limit register.
    input  logic                              cfg_wr_en,
    input  logic [lru_pr_pkg::LIM_W-1:0]      cfg_wr_data,
    // Page accesses.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] page
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] hit, [1] evicted, [33:2] victim, [65:34] hit_total,
    // [97:66] fault_total, rest zero.
    output logic [lru_pr_pkg::OUT_W-1:0]      m_tdata
);

    logic                              in_vld_reg;
    logic [lru_pr_pkg::PAGE_W-1:0]     in_page_reg;
    logic                              out_vld_reg;
    logic                              out_hit_reg;
    logic                              out_evict_reg;
    logic [lru_pr_pkg::PAGE_W-1:0]     out_victim_reg;
    logic [lru_pr_pkg::CNT_W-1:0]      hit_cnt_reg;
    logic [lru_pr_pkg::CNT_W-1:0]      hit_cnt_next;
    logic [lru_pr_pkg::CNT_W-1:0]      fault_cnt_reg;
    logic [lru_pr_pkg::CNT_W-1:0]      fault_cnt_next;
    logic [lru_pr_pkg::LIM_W-1:0]      lim_reg;
    logic [lru_pr_pkg::FILL_W-1:0]     lim_eff;
    logic                              process;
    lru_pr_pkg::lookup_t               lookup;

    // The item in the input register moves on when the result slot frees up.
    assign process  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || process;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_page_reg <= s_tdata[lru_pr_pkg::PAGE_W-1:0];
        end
    end

    // Frame limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= lru_pr_pkg::LIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            lim_reg <= cfg_wr_data;
        end
    end

    // A limit of zero acts as one, and any limit above the built size as the size.
    always_comb
    begin
        if (lim_reg == '0)
        begin
            lim_eff = lru_pr_pkg::FILL_W'(1);
        end
        else if (int'(lim_reg) > lru_pr_pkg::FRAMES)
        begin
            lim_eff = lru_pr_pkg::FILL_W'(lru_pr_pkg::FRAMES);
        end
        else
        begin
            lim_eff = lru_pr_pkg::FILL_W'(lim_reg);
        end
    end

    lru_pr_frames u_frames
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (process),
        .page   (in_page_reg),
        .lim    (lim_eff),
        .lookup (lookup)
    );

    // Saturating hit and fault counters.
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        if (lookup.hit)
        begin
            if (hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + lru_pr_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (fault_cnt_reg != '1)
            begin
                fault_cnt_next = fault_cnt_reg + lru_pr_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else if (process)
        begin
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (process)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_hit_reg    <= lookup.hit;
            out_evict_reg  <= lookup.evicted;
            out_victim_reg <= lookup.victim;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(lru_pr_pkg::OUT_W - lru_pr_pkg::OUT_BITS)'(0),
                       fault_cnt_reg, hit_cnt_reg, out_victim_reg,
                       out_evict_reg, out_hit_reg};

    // A result is either a hit or a fault, and only an eviction names a victim.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_hit_reg && out_evict_reg))
        else $error("result is both a hit and an eviction");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_evict_reg |-> out_victim_reg == '0)
        else $error("victim page set without an eviction");

    // Exactly one of the two counters moves per processed item, unless saturated.
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        process && (hit_cnt_reg != '1) && (fault_cnt_reg != '1) |=>
        (hit_cnt_reg != $past(hit_cnt_reg)) != (fault_cnt_reg != $past(fault_cnt_reg)))
        else $error("counters did not advance by exactly one item");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(hit_cnt_reg) && $stable(fault_cnt_reg))
        else $error("counter changed with no item processed");

endmodule
